// File: design/bfos_pkg.sv
// Shared types, codes and constants of the brush falloff offset store.
// No dependencies; every design file but bfos_ram imports this package.
package bfos_pkg;

  localparam int VERTEX_COUNT = 4096;
  localparam int IDX_W        = $clog2(VERTEX_COUNT);
  localparam int ENTRY_W      = 33;  // {pin, distance}
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 16;
  localparam int STEP_W       = 5;
  localparam int CFG_AW       = 5;

  localparam logic [31:0] RST_DEFAULT_DIST = 32'h0001_0000;
  localparam logic [31:0] RST_RADIUS       = 32'h0001_0000;
  localparam logic [2:0]  RST_CURVE        = 3'd1;
  localparam logic [16:0] ONE_Q16          = 17'h1_0000;
  localparam logic [17:0] SMOOTH_K         = 18'd196608;

  // Input actions
  localparam logic [2:0] ACT_TWEAK     = 3'd0;
  localparam logic [2:0] ACT_SET       = 3'd1;
  localparam logic [2:0] ACT_CLEAR     = 3'd2;
  localparam logic [2:0] ACT_RESET     = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;
  localparam logic [2:0] ACT_RESET_ALL = 3'd5;

  // Falloff curves
  localparam logic [2:0] CURVE_CONST  = 3'd0;
  localparam logic [2:0] CURVE_LINEAR = 3'd1;
  localparam logic [2:0] CURVE_SMOOTH = 3'd2;
  localparam logic [2:0] CURVE_SHARP  = 3'd3;
  localparam logic [2:0] CURVE_ROOT   = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_DEFAULT = 3'd0;
  localparam logic [2:0] REG_CX      = 3'd1;
  localparam logic [2:0] REG_CY      = 3'd2;
  localparam logic [2:0] REG_CZ      = 3'd3;
  localparam logic [2:0] REG_RADIUS  = 3'd4;
  localparam logic [2:0] REG_CURVE   = 3'd5;
  localparam logic [2:0] REG_DELTA   = 3'd6;

  typedef struct packed {
    logic [31:0]        default_distance;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        radius;
    logic [2:0]         curve;
    logic signed [31:0] delta;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SQUARE,
    OP_ACCUM,
    OP_SQRT_LD,
    OP_ROOT_LD,
    OP_SQRT_STEP,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_SHAPE,
    OP_SQR,
    OP_CURVE,
    OP_ROOTW,
    OP_FULL,
    OP_SCALE
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [1:0]       axis;
    logic             ram_re;
    logic             sweep;     // address from sweep counter, write fill value
    logic             fill_rst;  // fill with the reset distance, not the register
    logic [IDX_W-1:0] sweep_addr;
    logic             finish;    // write result back and load output word
    logic             mod;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       alive;
    logic       pin;
    logic       far;
    logic       ovf;
    logic       sum_zero;
    logic       dist_far;
    logic       curve_root;
    logic       w_zero;
  } stat_t;

endpackage

// File: design/brush_falloff_offset_store_core.sv
// Top level of the brush falloff offset store.
// Depends on bfos_pkg, bfos_cfg, bfos_ctrl, bfos_dp (and bfos_ram below it).
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | action, index, alive, position, new distance
//  out_    | output    | out_valid/out_stall| entry distance, pinned, modified
//  cfg_    | input     | APB psel/penable   | seven registers at 4*i (curve: 3 bits)
//
// One item at a time. Read, set, clear and reset vertex pass through load, read,
// decide and finish; a tweak also runs the 32-step square root (twice for the root
// curve) and the 16-step divider; reset all writes one store entry a cycle.
// After reset a clearing pass fills all 4096 store entries; items wait.
// The result word waits in an output register while out_stall is high.
module brush_falloff_offset_store_core
  import bfos_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [IDX_W-1:0]   in_vertex_index,
  input  logic               in_vertex_alive,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_new_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_entry_distance,
  output logic               out_entry_pinned,
  output logic               out_was_modified,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t st;

  assign cfg_pready = 1'b1;

  bfos_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .cfg    (cfg)
  );

  bfos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bfos_dp u_dp (
    .clk               (clk),
    .cfg               (cfg),
    .cmd               (cmd),
    .st                (st),
    .in_action         (in_action),
    .in_vertex_index   (in_vertex_index),
    .in_vertex_alive   (in_vertex_alive),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_new_distance   (in_new_distance),
    .out_entry_distance(out_entry_distance),
    .out_entry_pinned  (out_entry_pinned),
    .out_was_modified  (out_was_modified)
  );

endmodule

// File: design/bfos_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bfos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/bfos_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on bfos_pkg.
module bfos_cfg
  import bfos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_distance <= RST_DEFAULT_DIST;
      cfg_r.center_x         <= '0;
      cfg_r.center_y         <= '0;
      cfg_r.center_z         <= '0;
      cfg_r.radius           <= RST_RADIUS;
      cfg_r.curve            <= RST_CURVE;
      cfg_r.delta            <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_DEFAULT: cfg_r.default_distance <= pwdata;
        REG_CX:      cfg_r.center_x         <= pwdata;
        REG_CY:      cfg_r.center_y         <= pwdata;
        REG_CZ:      cfg_r.center_z         <= pwdata;
        REG_RADIUS:  cfg_r.radius           <= pwdata;
        REG_CURVE:   cfg_r.curve            <= pwdata[2:0];
        REG_DELTA:   cfg_r.delta            <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEFAULT: prdata = cfg_r.default_distance;
      REG_CX:      prdata = cfg_r.center_x;
      REG_CY:      prdata = cfg_r.center_y;
      REG_CZ:      prdata = cfg_r.center_z;
      REG_RADIUS:  prdata = cfg_r.radius;
      REG_CURVE:   prdata = {29'd0, cfg_r.curve};
      REG_DELTA:   prdata = cfg_r.delta;
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: design/bfos_dp.sv
// Datapath: item registers, vertex store, shared square root and divider,
// falloff curves, scaling and the output word. Depends on bfos_pkg, bfos_ram.
module bfos_dp
  import bfos_pkg::*;
(
  input  logic               clk,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [2:0]         in_action,
  input  logic [IDX_W-1:0]   in_vertex_index,
  input  logic               in_vertex_alive,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_new_distance,
  output logic [31:0]        out_entry_distance,
  output logic               out_entry_pinned,
  output logic               out_was_modified
);

  logic [2:0]         act_r;
  logic [IDX_W-1:0]   idx_r;
  logic               alive_r;
  logic signed [31:0] px_r, py_r, pz_r, nd_r;
  logic [32:0]        a_r;
  logic [63:0]        sq_r, sum_r, sx_r;
  logic               ovf_r;
  logic [33:0]        srem_r;
  logic [31:0]        sroot_r;
  logic [32:0]        drem_r;
  logic [15:0]        q_r;
  logic [16:0]        s_r, w_r;
  logic [33:0]        ss_r;
  logic signed [49:0] prod_r;
  logic [31:0]        odist_r;
  logic               opin_r, omod_r;

  logic [31:0]        r_eff;
  logic signed [31:0] p_sel, c_sel;
  logic signed [32:0] diff;
  logic [64:0]        acc;
  logic [35:0]        rem_t, trial;
  logic [32:0]        dt;
  logic [51:0]        smooth_p;
  logic [ENTRY_W-1:0] ram_rdata, ram_wdata, res_entry;
  logic [IDX_W-1:0]   ram_addr;
  logic [31:0]        ent_dist;
  logic               ent_pin;
  logic signed [33:0] inc;
  logic signed [34:0] nv;
  logic [31:0]        tweak_dist;
  logic [31:0]        fill_dist;

  assign r_eff    = (cfg.radius == '0) ? 32'd1 : cfg.radius;
  assign ent_dist = ram_rdata[31:0];
  assign ent_pin  = ram_rdata[32];

  always_comb begin
    case (cmd.axis)
      2'd0:    begin p_sel = px_r; c_sel = cfg.center_x; end
      2'd1:    begin p_sel = py_r; c_sel = cfg.center_y; end
      default: begin p_sel = pz_r; c_sel = cfg.center_z; end
    endcase
  end

  assign diff     = {p_sel[31], p_sel} - {c_sel[31], c_sel};
  assign acc      = {1'b0, sum_r} + {1'b0, sq_r};
  assign rem_t    = {srem_r, sx_r[63:62]};
  assign trial    = {2'b00, sroot_r, 2'b01};
  assign dt       = {drem_r[31:0], 1'b0};
  assign smooth_p = ss_r * (SMOOTH_K - {s_r, 1'b0});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r   <= in_action;
        idx_r   <= in_vertex_index;
        alive_r <= in_vertex_alive;
        px_r    <= in_pos_x;
        py_r    <= in_pos_y;
        pz_r    <= in_pos_z;
        nd_r    <= in_new_distance;
        sum_r   <= '0;
        ovf_r   <= 1'b0;
      end
      OP_DIFF:   a_r  <= diff[32] ? 33'(-diff) : 33'(diff);
      OP_SQUARE: sq_r <= a_r[31:0] * a_r[31:0];
      OP_ACCUM: begin
        sum_r <= acc[63:0];
        ovf_r <= ovf_r | acc[64];
      end
      OP_SQRT_LD: begin
        sx_r    <= sum_r;
        srem_r  <= '0;
        sroot_r <= '0;
      end
      OP_ROOT_LD: begin
        sx_r    <= {31'd0, s_r, 16'd0};
        srem_r  <= '0;
        sroot_r <= '0;
      end
      OP_SQRT_STEP: begin
        sx_r <= {sx_r[61:0], 2'b00};
        if (rem_t >= trial) begin
          srem_r  <= 34'(rem_t - trial);
          sroot_r <= {sroot_r[30:0], 1'b1};
        end else begin
          srem_r  <= rem_t[33:0];
          sroot_r <= {sroot_r[30:0], 1'b0};
        end
      end
      OP_DIV_LD: begin
        drem_r <= {1'b0, sroot_r};
        q_r    <= '0;
      end
      OP_DIV_STEP: begin
        if (dt >= {1'b0, r_eff}) begin
          drem_r <= dt - {1'b0, r_eff};
          q_r    <= {q_r[14:0], 1'b1};
        end else begin
          drem_r <= dt;
          q_r    <= {q_r[14:0], 1'b0};
        end
      end
      OP_SHAPE: s_r  <= ONE_Q16 - {1'b0, q_r};
      OP_SQR:   ss_r <= {17'd0, s_r} * {17'd0, s_r};
      OP_CURVE: begin
        case (cfg.curve)
          CURVE_CONST:  w_r <= ONE_Q16;
          CURVE_LINEAR: w_r <= s_r;
          CURVE_SMOOTH: w_r <= smooth_p[48:32];
          CURVE_SHARP:  w_r <= ss_r[32:16];
          default:      w_r <= '0;
        endcase
      end
      OP_ROOTW: w_r    <= sroot_r[16:0];
      OP_FULL:  w_r    <= ONE_Q16;
      OP_SCALE: prod_r <= cfg.delta * $signed({1'b0, w_r});
      default: ;
    endcase
  end

  // Tweak result: floor of the scaled change, saturated to the unsigned range
  assign inc = 34'(prod_r >>> 16);
  assign nv  = $signed({3'b000, ent_dist}) + 35'(inc);
  always_comb begin
    if (nv < 0) begin
      tweak_dist = '0;
    end else if (nv[34:32] != 3'b000) begin
      tweak_dist = '1;
    end else begin
      tweak_dist = nv[31:0];
    end
  end

  always_comb begin
    case (act_r)
      ACT_TWEAK: res_entry = cmd.mod ? {ent_pin, tweak_dist} : ram_rdata;
      ACT_SET:   res_entry = {1'b1, nd_r[31] ? 32'd0 : 32'(nd_r)};
      ACT_CLEAR: res_entry = {1'b0, ent_dist};
      ACT_RESET, ACT_RESET_ALL: res_entry = {1'b0, cfg.default_distance};
      default:   res_entry = ram_rdata;
    endcase
  end

  assign fill_dist = cmd.fill_rst ? RST_DEFAULT_DIST : cfg.default_distance;
  assign ram_addr  = cmd.sweep ? cmd.sweep_addr : idx_r;
  assign ram_wdata = cmd.sweep ? {1'b0, fill_dist} : res_entry;

  bfos_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(VERTEX_COUNT)
  ) u_store (
    .clk  (clk),
    .addr (ram_addr),
    .we   (cmd.sweep || cmd.finish),
    .wdata(ram_wdata),
    .re   (cmd.ram_re),
    .rdata(ram_rdata)
  );

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      odist_r <= res_entry[31:0];
      opin_r  <= res_entry[32];
      omod_r  <= cmd.mod && (act_r == ACT_TWEAK);
    end
  end

  assign out_entry_distance = odist_r;
  assign out_entry_pinned   = opin_r;
  assign out_was_modified   = omod_r;

  assign st.action     = act_r;
  assign st.alive      = alive_r;
  assign st.pin        = ent_pin;
  assign st.far        = a_r >= {1'b0, r_eff};
  assign st.ovf        = ovf_r;
  assign st.sum_zero   = (sum_r == '0);
  assign st.dist_far   = sroot_r >= r_eff;
  assign st.curve_root = (cfg.curve == CURVE_ROOT);
  assign st.w_zero     = (w_r == '0);

endmodule

// File: design/bfos_ctrl.sv
// Controller: sequences store sweeps, the tweak arithmetic and the handshakes.
// Depends on bfos_pkg.
module bfos_ctrl
  import bfos_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_DECIDE, S_DIFF, S_SQUARE, S_ACCUM, S_CHECK,
    S_SQRT, S_DIVLD, S_DIV, S_SHAPE, S_SQR, S_CURVE, S_ROOT, S_ROOTW,
    S_SCALE, S_FILL, S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic              mod_r, mod_nxt;
  logic [IDX_W-1:0]  sweep_r, sweep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_sweep;

  assign last_sweep = (sweep_r == '1);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    axis_nxt       = axis_r;
    mod_nxt        = mod_r;
    sweep_nxt      = sweep_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.axis       = axis_r;
    cmd.sweep_addr = sweep_r;
    cmd.mod        = mod_r;

    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep    = 1'b1;
        cmd.fill_rst = 1'b1;
        sweep_nxt    = sweep_r + 1'b1;
        if (last_sweep) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          mod_nxt   = 1'b0;
          axis_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.ram_re = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.action == ACT_RESET_ALL) begin
          sweep_nxt = '0;
          state_nxt = S_FILL;
        end else if (st.action == ACT_TWEAK && st.alive && !st.pin) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        if (st.far) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_SQUARE;
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.op = OP_ACCUM;
        if (axis_r == 2'd2) begin
          state_nxt = S_CHECK;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_CHECK: begin
        if (st.ovf) begin
          state_nxt = S_FINISH;
        end else if (st.sum_zero) begin
          cmd.op    = OP_FULL;
          state_nxt = S_SCALE;
        end else begin
          cmd.op    = OP_SQRT_LD;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        if (st.dist_far) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_DIV_LD;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_SHAPE;
      end
      S_SHAPE: begin
        cmd.op    = OP_SHAPE;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.op    = OP_SQR;
        state_nxt = S_CURVE;
      end
      S_CURVE: begin
        if (st.curve_root) begin
          cmd.op    = OP_ROOT_LD;
          step_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          cmd.op    = OP_CURVE;
          state_nxt = S_SCALE;
        end
      end
      S_ROOT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_ROOTW;
      end
      S_ROOTW: begin
        cmd.op    = OP_ROOTW;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (!st.w_zero) begin
          cmd.op  = OP_SCALE;
          mod_nxt = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_FILL: begin
        cmd.sweep = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (last_sweep) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output word is free or being taken
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      axis_r      <= '0;
      mod_r       <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      mod_r       <= mod_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !(cmd.finish || cmd.sweep))
    else $error("store written while idle");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished word not presented");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled output word dropped");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r < STEP_W'(DIV_STEPS))
    else $error("divider overran");

endmodule
